FILE: design/tvmm_pkg.sv
// ----------------------------------------------------------------------------
// tvmm_pkg
// Shared types and constants for the masked multiplane text memory.
// ----------------------------------------------------------------------------
package tvmm_pkg;

    // words per plane; a power of two, the word offset wraps on its low bits
    localparam int PLANE_WORDS = 65536;
    localparam int OFS_W       = $clog2(PLANE_WORDS);
    localparam int NUM_PLANES  = 4;

    localparam logic [1:0] OP_READ_BYTE  = 2'd0;
    localparam logic [1:0] OP_READ_WORD  = 2'd1;
    localparam logic [1:0] OP_WRITE_BYTE = 2'd2;
    localparam logic [1:0] OP_WRITE_WORD = 2'd3;

    localparam logic CFG_PLANE_SELECT = 1'b0;
    localparam logic CFG_WRITE_MASK   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [18:0] address;
        logic [15:0] write_data;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        wait_inserted;
        logic        changed;
        logic [18:0] changed_address;
    } rsp_t;

endpackage

FILE: design/text_vram_masked_multiplane_access.sv
// ----------------------------------------------------------------------------
// text_vram_masked_multiplane_access
// Latency: the result strobes in the cycle after the accepting edge.
// Busy covers the read-modify-write cycle, so a new request is taken only
// once the last one has its result; set by the single port of each plane RAM.
// Reset: the control registers clear at once; busy then stays high while all
// PLANE_WORDS words of the four planes are swept to zero, one word a cycle.
// ----------------------------------------------------------------------------
module text_vram_masked_multiplane_access (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tvmm_pkg::req_t request,
    output logic           result_valid,
    output tvmm_pkg::rsp_t result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);
    import tvmm_pkg::*;

    state_t            state_reg, state_next;
    logic [OFS_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [1:0]        counter_reg, counter_next;
    logic [4:0]        plane_select_reg;
    logic [15:0]       write_mask_reg;
    req_t              req_reg;

    logic [OFS_W-1:0]  ram_addr;
    logic [15:0]       ram_rdata [NUM_PLANES];
    logic [15:0]       ram_wdata [NUM_PLANES];
    logic              ram_we    [NUM_PLANES];
    logic [15:0]       merged    [NUM_PLANES];

    logic              accept;
    logic              is_write;
    logic              multi;
    logic [1:0]        plane;
    logic [15:0]       keep;
    logic [15:0]       val;
    logic [15:0]       old_word;
    logic              any_change;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            counter_reg      <= '0;
            plane_select_reg <= '0;
            write_mask_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            counter_reg  <= counter_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PLANE_SELECT: plane_select_reg <= cfg_data[4:0];
                    CFG_WRITE_MASK:   write_mask_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        counter_next  = counter_reg;
        result_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == OFS_W'(PLANE_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    counter_next = counter_reg + 1'b1;
                    state_next   = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                result_valid = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority case (state_reg)
            ST_CLEAR: ram_addr = clr_addr_reg;
            ST_IDLE:  ram_addr = request.address[OFS_W:1];
            default:  ram_addr = req_reg.address[OFS_W:1];
        endcase
    end

    assign is_write = req_reg.opcode[1];
    assign multi    = (plane_select_reg != '0);
    assign plane    = req_reg.address[18:17];

    always_comb
    begin
        unique case (req_reg.opcode)
            OP_WRITE_BYTE:
            begin
                if (req_reg.address[0])
                begin
                    keep = {8'hff, write_mask_reg[7:0]};
                    val  = {8'h00, req_reg.write_data[7:0]};
                end
                else
                begin
                    keep = {write_mask_reg[15:8], 8'hff};
                    val  = {req_reg.write_data[7:0], 8'h00};
                end
            end
            default:
            begin
                keep = write_mask_reg;
                val  = req_reg.write_data;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            merged[k] = (ram_rdata[k] & keep) | (val & ~keep);
            if (state_reg == ST_CLEAR)
            begin
                ram_we[k]    = 1'b1;
                ram_wdata[k] = '0;
            end
            else
            begin
                ram_we[k]    = (state_reg == ST_MERGE) && is_write
                               && (multi ? plane_select_reg[k] : (plane == 2'(k)))
                               && (merged[k] != ram_rdata[k]);
                ram_wdata[k] = merged[k];
            end
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_plane
        tvmm_plane_ram u_ram (
            .clk   (clk),
            .addr  (ram_addr),
            .we    (ram_we[g]),
            .wdata (ram_wdata[g]),
            .rdata (ram_rdata[g])
        );
    end

    assign old_word   = ram_rdata[plane];
    assign any_change = ram_we[0] || ram_we[1] || ram_we[2] || ram_we[3];

    always_comb
    begin
        result.wait_inserted   = (counter_reg != '0);
        result.changed         = is_write && any_change;
        result.read_data       = '0;
        result.changed_address = '0;
        unique case (req_reg.opcode)
            OP_READ_BYTE:
            begin
                result.read_data = req_reg.address[0] ? {8'h00, old_word[7:0]}
                                                      : {8'h00, old_word[15:8]};
            end
            OP_READ_WORD:
            begin
                result.read_data = old_word;
            end
            OP_WRITE_BYTE:
            begin
                if (any_change)
                begin
                    result.changed_address = multi
                        ? {2'b11, req_reg.address[16:1], ~req_reg.address[0]}
                        : {req_reg.address[18:1], ~req_reg.address[0]};
                end
            end
            OP_WRITE_WORD:
            begin
                if (any_change)
                begin
                    result.changed_address = multi
                        ? {2'b11, req_reg.address[16:1], 1'b0}
                        : {req_reg.address[18:1], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: design/tvmm_plane_ram.sv
// ----------------------------------------------------------------------------
// tvmm_plane_ram
// One bit plane: single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tvmm_plane_ram (
    input  logic                      clk,
    input  logic [tvmm_pkg::OFS_W-1:0] addr,
    input  logic                      we,
    input  logic [15:0]               wdata,
    output logic [15:0]               rdata
);
    import tvmm_pkg::*;

    logic [15:0] mem [PLANE_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/tvmm_checker.sv
// ----------------------------------------------------------------------------
// tvmm_checker
// Port-level checks on the masked multiplane text memory, bound to the top.
// ----------------------------------------------------------------------------
module tvmm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input tvmm_pkg::req_t request,
    input logic           result_valid,
    input tvmm_pkg::rsp_t result
);
    import tvmm_pkg::*;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> result_valid)
        else $error("accepted request produced no result");

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a busy cycle");

    a_no_change_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.changed) |-> (result.changed_address == '0))
        else $error("notify address without change");

    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(request.opcode[1])) |-> (result.read_data == '0))
        else $error("write returned read data");

endmodule

bind text_vram_masked_multiplane_access tvmm_checker u_tvmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);
